// File: src/rtc_with_periodic_interrupt_timer_core_defines.svh
// ----------------------------------------------------------------------------
// RTC/PIT core assertion macros
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef RTC_WITH_PERIODIC_INTERRUPT_TIMER_CORE_DEFINES_SVH
`define RTC_WITH_PERIODIC_INTERRUPT_TIMER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPIT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpit: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define RPIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpit: next-cycle property failed");

`endif

// File: src/rpit_pkg.sv
// ----------------------------------------------------------------------------
// RTC/PIT package
// Item types, command codes, register offsets and small helper functions.
// ----------------------------------------------------------------------------
package rpit_pkg;

  localparam int unsigned SYNC_BUSY_TICKS_DEF = 64;
  localparam int unsigned BUSY_W              = 7;
  localparam int unsigned PRESC_W             = 11;
  localparam int unsigned PIT_CNT_W           = 17;
  localparam logic [3:0]  PRESC_MAX_EXP       = 4'd10;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_ACK   = 2'd3
  } rpit_cmd_e;

  localparam logic [1:0] ACK_NONE = 2'd0;
  localparam logic [1:0] ACK_RTC  = 2'd1;
  localparam logic [1:0] ACK_PIT  = 2'd2;

  localparam logic [4:0] ADDR_CTRLA       = 5'd0;
  localparam logic [4:0] ADDR_STATUS      = 5'd1;
  localparam logic [4:0] ADDR_INTCTRL     = 5'd2;
  localparam logic [4:0] ADDR_INTFLAGS    = 5'd3;
  localparam logic [4:0] ADDR_TEMP        = 5'd4;
  localparam logic [4:0] ADDR_CNTL        = 5'd8;
  localparam logic [4:0] ADDR_CNTH        = 5'd9;
  localparam logic [4:0] ADDR_PERL        = 5'd10;
  localparam logic [4:0] ADDR_PERH        = 5'd11;
  localparam logic [4:0] ADDR_CMPL        = 5'd12;
  localparam logic [4:0] ADDR_CMPH        = 5'd13;
  localparam logic [4:0] ADDR_PITCTRLA    = 5'd16;
  localparam logic [4:0] ADDR_PITSTATUS   = 5'd17;
  localparam logic [4:0] ADDR_PITINTCTRL  = 5'd18;
  localparam logic [4:0] ADDR_PITINTFLAGS = 5'd19;

  // Status busy bits.
  localparam logic [7:0] BUSY_CTRLA = 8'h01;
  localparam logic [7:0] BUSY_PER   = 8'h02;
  localparam logic [7:0] BUSY_CMP   = 8'h08;
  localparam logic [7:0] BUSY_CNT   = 8'h10;

  localparam logic [15:0] PER_RESET = 16'hFFFF;

  typedef struct packed {
    rpit_cmd_e  command;
    logic [4:0] address;
    logic [7:0] write_data;
  } rpit_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       overflow_event;
    logic       compare_event;
    logic       rtc_irq_pending;
    logic       pit_irq_pending;
    logic [1:0] ack_vector;
  } rpit_out_t;

  // What one timer unit reports for the item it has just processed.
  typedef struct packed {
    logic [7:0] read_data;
    logic       overflow_event;
    logic       compare_event;
    logic       irq_pending;
    logic       taken;
  } rpit_unit_res_t;

  // RTC prescaler divider: 2^min(p, 10).
  function automatic logic [PRESC_W-1:0] presc_div(input logic [3:0] p);
    logic [3:0] e;
    e = (p > PRESC_MAX_EXP) ? PRESC_MAX_EXP : p;
    return PRESC_W'(1) << e;
  endfunction

  // PIT period: 4 for p = 0, otherwise 2^(p+1).
  function automatic logic [PIT_CNT_W-1:0] pit_period(input logic [3:0] p);
    logic [4:0] e;
    e = {1'b0, p} + 5'd1;
    return (p == 4'd0) ? PIT_CNT_W'(4) : (PIT_CNT_W'(1) << e);
  endfunction

endpackage

// File: src/rtc_with_periodic_interrupt_timer_core.sv
// ----------------------------------------------------------------------------
// RTC with periodic interrupt timer - core
// Byte-wide register block with a real-time counter and a periodic timer,
// driven one item at a time by reads, writes, clock ticks and acknowledges.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+-----------------------
//   in      | input     | in_valid_i / in_stall_o | in_data_i  (rpit_in_t)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (rpit_out_t)
//
// One item is accepted every clock cycle while the output side keeps up.
// An item passes through the input register and then the result register;
// the state update and result are formed between the two.
// The reset is asynchronous and active low; it clears the valid bits and
// all timer state, with the period register returning to 0xFFFF.
// A stall on the output holds the result register; the input then stalls
// in the same cycle once its register is occupied, so no item is lost.
//
module rtc_with_periodic_interrupt_timer_core
  import rpit_pkg::*;
#(
  parameter int unsigned SYNC_BUSY_TICKS = SYNC_BUSY_TICKS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  rpit_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output rpit_out_t out_data_o
);

  // Input register: holds the item being worked on this cycle.
  logic      in_valid_q, in_valid_d;
  rpit_in_t  in_item_q;

  // Result register: holds a finished result until the sink takes it.
  logic      out_valid_q, out_valid_d;
  rpit_out_t out_item_q, out_item_d;

  logic in_accept;
  logic out_ready;
  logic advance;

  rpit_unit_res_t rtc_res;
  rpit_unit_res_t pit_res;

  // The result register can take a new result when it is empty or when its
  // current result leaves in this cycle.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Both units see the same item; each updates its own registers only when
  // the item actually moves into the result register.
  rpit_rtc #(
    .SYNC_BUSY_TICKS(SYNC_BUSY_TICKS)
  ) u_rtc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_item_q),
    .res_o  (rtc_res)
  );

  // The RTC vector has priority on an acknowledge, so the PIT is told when
  // the RTC has already taken it.
  rpit_pit #(
    .SYNC_BUSY_TICKS(SYNC_BUSY_TICKS)
  ) u_pit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_item_q),
    .rtc_taken_i (rtc_res.taken),
    .res_o       (pit_res)
  );

  always_comb begin
    out_item_d.read_data       = rtc_res.read_data | pit_res.read_data;
    out_item_d.overflow_event  = rtc_res.overflow_event;
    out_item_d.compare_event   = rtc_res.compare_event;
    out_item_d.rtc_irq_pending = rtc_res.irq_pending;
    out_item_d.pit_irq_pending = pit_res.irq_pending;
    if (rtc_res.taken) begin
      out_item_d.ack_vector = ACK_RTC;
    end else if (pit_res.taken) begin
      out_item_d.ack_vector = ACK_PIT;
    end else begin
      out_item_d.ack_vector = ACK_NONE;
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset; their valid bits guard them.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_data_i;
    end
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

// File: src/rpit_rtc.sv
// ----------------------------------------------------------------------------
// RTC unit
// Real-time counter registers, prescaler, busy count and interrupt flags.
// ----------------------------------------------------------------------------
module rpit_rtc
  import rpit_pkg::*;
#(
  parameter int unsigned SYNC_BUSY_TICKS = SYNC_BUSY_TICKS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  rpit_in_t       item_i,
  output rpit_unit_res_t res_o
);

  logic [7:0]         ctrla_q, ctrla_d;
  logic [7:0]         status_q, status_d;
  logic [7:0]         intctrl_q, intctrl_d;
  logic [1:0]         flags_q, flags_d;
  logic [7:0]         temp_q, temp_d;
  logic [15:0]        cnt_q, cnt_d;
  logic [15:0]        per_q, per_d;
  logic [15:0]        cmp_q, cmp_d;
  logic [PRESC_W-1:0] presc_q, presc_d;
  logic [BUSY_W-1:0]  busy_q, busy_d;

  logic [PRESC_W-1:0] presc_inc;
  logic [15:0]        cnt_next;
  logic [15:0]        joined;

  assign presc_inc = presc_q + PRESC_W'(1);
  assign joined    = {temp_q, item_i.write_data};
  assign cnt_next  = (cnt_q == per_q) ? 16'd0 : cnt_q + 16'd1;

  always_comb begin
    ctrla_d   = ctrla_q;
    status_d  = status_q;
    intctrl_d = intctrl_q;
    flags_d   = flags_q;
    temp_d    = temp_q;
    cnt_d     = cnt_q;
    per_d     = per_q;
    cmp_d     = cmp_q;
    presc_d   = presc_q;
    busy_d    = busy_q;
    res_o     = '0;

    case (item_i.command)
      CMD_READ: begin
        case (item_i.address)
          ADDR_CTRLA:    res_o.read_data = ctrla_q;
          ADDR_STATUS:   res_o.read_data = status_q;
          ADDR_INTCTRL:  res_o.read_data = intctrl_q;
          ADDR_INTFLAGS: res_o.read_data = {6'd0, flags_q};
          ADDR_TEMP, ADDR_CNTH, ADDR_PERH, ADDR_CMPH: res_o.read_data = temp_q;
          ADDR_CNTL: begin
            res_o.read_data = cnt_q[7:0];
            temp_d          = cnt_q[15:8];
          end
          ADDR_PERL: begin
            res_o.read_data = per_q[7:0];
            temp_d          = per_q[15:8];
          end
          ADDR_CMPL: begin
            res_o.read_data = cmp_q[7:0];
            temp_d          = cmp_q[15:8];
          end
          default: res_o.read_data = 8'd0;
        endcase
      end
      CMD_WRITE: begin
        case (item_i.address)
          ADDR_CTRLA: begin
            ctrla_d  = item_i.write_data;
            status_d = status_q | BUSY_CTRLA;
            busy_d   = BUSY_W'(SYNC_BUSY_TICKS);
          end
          ADDR_INTCTRL:  intctrl_d = item_i.write_data;
          ADDR_INTFLAGS: flags_d   = flags_q & ~item_i.write_data[1:0];
          ADDR_TEMP, ADDR_CNTH, ADDR_PERH, ADDR_CMPH: temp_d = item_i.write_data;
          ADDR_CNTL: begin
            cnt_d    = joined;
            status_d = status_q | BUSY_CNT;
            busy_d   = BUSY_W'(SYNC_BUSY_TICKS);
          end
          ADDR_PERL: begin
            per_d    = joined;
            status_d = status_q | BUSY_PER;
            busy_d   = BUSY_W'(SYNC_BUSY_TICKS);
          end
          ADDR_CMPL: begin
            cmp_d    = joined;
            status_d = status_q | BUSY_CMP;
            busy_d   = BUSY_W'(SYNC_BUSY_TICKS);
          end
          default: ;
        endcase
      end
      CMD_TICK: begin
        if (busy_q != '0) begin
          if (busy_q == BUSY_W'(1)) begin
            busy_d   = '0;
            status_d = 8'd0;
          end else begin
            busy_d = busy_q - BUSY_W'(1);
          end
        end
        if (ctrla_q[0]) begin
          if (presc_inc >= presc_div(ctrla_q[6:3])) begin
            presc_d = '0;
            cnt_d   = cnt_next;
            if (cnt_q == per_q) begin
              flags_d[0]           = 1'b1;
              res_o.overflow_event = 1'b1;
            end
            if (cnt_next == cmp_q) begin
              flags_d[1]          = 1'b1;
              res_o.compare_event = 1'b1;
            end
          end else begin
            presc_d = presc_inc;
          end
        end
      end
      CMD_ACK: begin
        if ((flags_q & intctrl_q[1:0]) != 2'd0) begin
          flags_d     = 2'd0;
          res_o.taken = 1'b1;
        end
      end
      default: ;
    endcase

    res_o.irq_pending = (flags_d & intctrl_d[1:0]) != 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrla_q   <= 8'd0;
      status_q  <= 8'd0;
      intctrl_q <= 8'd0;
      flags_q   <= 2'd0;
      temp_q    <= 8'd0;
      cnt_q     <= 16'd0;
      per_q     <= PER_RESET;
      cmp_q     <= 16'd0;
      presc_q   <= '0;
      busy_q    <= '0;
    end else if (step_i) begin
      ctrla_q   <= ctrla_d;
      status_q  <= status_d;
      intctrl_q <= intctrl_d;
      flags_q   <= flags_d;
      temp_q    <= temp_d;
      cnt_q     <= cnt_d;
      per_q     <= per_d;
      cmp_q     <= cmp_d;
      presc_q   <= presc_d;
      busy_q    <= busy_d;
    end
  end

endmodule

// File: src/rpit_pit.sv
// ----------------------------------------------------------------------------
// PIT unit
// Periodic interrupt timer registers, period counter and busy count.
// ----------------------------------------------------------------------------
module rpit_pit
  import rpit_pkg::*;
#(
  parameter int unsigned SYNC_BUSY_TICKS = SYNC_BUSY_TICKS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  rpit_in_t       item_i,
  input  logic           rtc_taken_i,
  output rpit_unit_res_t res_o
);

  logic [7:0]           ctrl_q, ctrl_d;
  logic                 stat_q, stat_d;
  logic [7:0]           inten_q, inten_d;
  logic                 flag_q, flag_d;
  logic [PIT_CNT_W-1:0] cnt_q, cnt_d;
  logic [BUSY_W-1:0]    busy_q, busy_d;

  logic [PIT_CNT_W-1:0] cnt_inc;

  assign cnt_inc = cnt_q + PIT_CNT_W'(1);

  always_comb begin
    ctrl_d  = ctrl_q;
    stat_d  = stat_q;
    inten_d = inten_q;
    flag_d  = flag_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    res_o   = '0;

    case (item_i.command)
      CMD_READ: begin
        case (item_i.address)
          ADDR_PITCTRLA:    res_o.read_data = ctrl_q;
          ADDR_PITSTATUS:   res_o.read_data = {7'd0, stat_q};
          ADDR_PITINTCTRL:  res_o.read_data = inten_q;
          ADDR_PITINTFLAGS: res_o.read_data = {7'd0, flag_q};
          default:          res_o.read_data = 8'd0;
        endcase
      end
      CMD_WRITE: begin
        case (item_i.address)
          ADDR_PITCTRLA: begin
            ctrl_d = item_i.write_data;
            stat_d = 1'b1;
            busy_d = BUSY_W'(SYNC_BUSY_TICKS);
          end
          ADDR_PITINTCTRL:  inten_d = item_i.write_data;
          ADDR_PITINTFLAGS: flag_d  = flag_q & ~item_i.write_data[0];
          default: ;
        endcase
      end
      CMD_TICK: begin
        if (busy_q != '0) begin
          if (busy_q == BUSY_W'(1)) begin
            busy_d = '0;
            stat_d = 1'b0;
          end else begin
            busy_d = busy_q - BUSY_W'(1);
          end
        end
        if (ctrl_q[0]) begin
          if (cnt_inc >= pit_period(ctrl_q[6:3])) begin
            cnt_d  = '0;
            flag_d = 1'b1;
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end
      CMD_ACK: begin
        if (!rtc_taken_i && flag_q && inten_q[0]) begin
          flag_d      = 1'b0;
          res_o.taken = 1'b1;
        end
      end
      default: ;
    endcase

    res_o.irq_pending = flag_d & inten_d[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q  <= 8'd0;
      stat_q  <= 1'b0;
      inten_q <= 8'd0;
      flag_q  <= 1'b0;
      cnt_q   <= '0;
      busy_q  <= '0;
    end else if (step_i) begin
      ctrl_q  <= ctrl_d;
      stat_q  <= stat_d;
      inten_q <= inten_d;
      flag_q  <= flag_d;
      cnt_q   <= cnt_d;
      busy_q  <= busy_d;
    end
  end

endmodule

// File: src/rpit_checker.sv
// ----------------------------------------------------------------------------
// RTC/PIT port checker
// Concurrent properties on the core's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "rtc_with_periodic_interrupt_timer_core_defines.svh"

module rpit_checker
  import rpit_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input rpit_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input rpit_out_t out_data_o
);

  logic in_seen;

  assign in_seen = in_valid_i || (in_data_i.command == CMD_READ);

  // A stalled result stays offered and unchanged.
  `RPIT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // With no result waiting, the input never stalls.
  `RPIT_ASSERT_SAME(a_no_stall_when_empty, clk_i, rst_ni, !out_valid_o && in_seen, !in_stall_o)

  // Taking the RTC vector clears both RTC flags.
  `RPIT_ASSERT_SAME(a_rtc_ack_clears, clk_i, rst_ni, out_valid_o && (out_data_o.ack_vector == ACK_RTC), !out_data_o.rtc_irq_pending)

  // Taking the PIT vector clears the periodic flag.
  `RPIT_ASSERT_SAME(a_pit_ack_clears, clk_i, rst_ni, out_valid_o && (out_data_o.ack_vector == ACK_PIT), !out_data_o.pit_irq_pending)

endmodule

bind rtc_with_periodic_interrupt_timer_core rpit_checker u_rpit_checker (.*);

// File: sim/rtc_with_periodic_interrupt_timer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC/PIT core testbench
// Sends bus reads, bus writes, clock ticks and acknowledges into the core.
// Every reply is checked field by field against a timer model kept in this
// module or a given read byte. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module rtc_with_periodic_interrupt_timer_core_test;
  import rpit_pkg::*;

  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned PHASE_ITEMS     = 150;
  localparam int unsigned DRAIN_LIMIT     = 10000;
  localparam int unsigned SETTLE_CYCLES   = 8;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  rpit_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  rpit_out_t out_data_o;

  rtc_with_periodic_interrupt_timer_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // The watchdog is sized far beyond the slowest legal run: even with both
  // sides idling most of the time, the directed rows and four random phases
  // finish in well under a tenth of this.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Timer model. Its state mirrors the register block after reset; the period
  // register comes out of reset at its maximum value.
  // --------------------------------------------------------------------------
  logic [7:0]  ctl_a         = '0;
  logic [7:0]  rtc_status    = '0;
  logic [7:0]  rtc_int_en    = '0;
  logic [7:0]  rtc_int_fl    = '0;
  logic [7:0]  temp_byte     = '0;
  logic [15:0] cnt_q         = '0;
  logic [15:0] per_q         = PER_RESET;
  logic [15:0] cmp_q         = '0;
  logic [7:0]  pit_ctl       = '0;
  logic [7:0]  pit_status    = '0;
  logic [7:0]  pit_int_en    = '0;
  logic [7:0]  pit_int_fl    = '0;
  logic [10:0] presc_q       = '0;
  logic [16:0] pit_q         = '0;
  logic [6:0]  rtc_sync_left = '0;
  logic [6:0]  pit_sync_left = '0;

  // Works out the reply of the core to one item and moves the model on.
  function automatic rpit_out_t rtc_pit_reply(input rpit_in_t item);
    rpit_out_t   res;
    logic [3:0]  p;
    logic [10:0] div;
    logic [16:0] pit_len;
    res = '0;
    case (item.command)
      CMD_READ: begin
        case (item.address)
          ADDR_CTRLA:       res.read_data = ctl_a;
          ADDR_STATUS:      res.read_data = rtc_status;
          ADDR_INTCTRL:     res.read_data = rtc_int_en;
          ADDR_INTFLAGS:    res.read_data = rtc_int_fl;
          ADDR_TEMP:        res.read_data = temp_byte;
          // A low byte read latches the high byte, so that a later high
          // byte read returns a coherent 16-bit value.
          ADDR_CNTL: begin
            temp_byte     = cnt_q[15:8];
            res.read_data = cnt_q[7:0];
          end
          ADDR_PERL: begin
            temp_byte     = per_q[15:8];
            res.read_data = per_q[7:0];
          end
          ADDR_CMPL: begin
            temp_byte     = cmp_q[15:8];
            res.read_data = cmp_q[7:0];
          end
          ADDR_CNTH, ADDR_PERH, ADDR_CMPH: res.read_data = temp_byte;
          ADDR_PITCTRLA:    res.read_data = pit_ctl;
          ADDR_PITSTATUS:   res.read_data = pit_status;
          ADDR_PITINTCTRL:  res.read_data = pit_int_en;
          ADDR_PITINTFLAGS: res.read_data = pit_int_fl;
          default:          res.read_data = '0;
        endcase
      end
      CMD_WRITE: begin
        case (item.address)
          ADDR_CTRLA: begin
            ctl_a         = item.write_data;
            rtc_status    = rtc_status | BUSY_CTRLA;
            rtc_sync_left = 7'(SYNC_BUSY_TICKS_DEF);
          end
          ADDR_INTCTRL:  rtc_int_en = item.write_data;
          ADDR_INTFLAGS: rtc_int_fl = rtc_int_fl & ~item.write_data;
          ADDR_TEMP, ADDR_CNTH, ADDR_PERH, ADDR_CMPH: temp_byte = item.write_data;
          ADDR_CNTL: begin
            cnt_q         = {temp_byte, item.write_data};
            rtc_status    = rtc_status | BUSY_CNT;
            rtc_sync_left = 7'(SYNC_BUSY_TICKS_DEF);
          end
          ADDR_PERL: begin
            per_q         = {temp_byte, item.write_data};
            rtc_status    = rtc_status | BUSY_PER;
            rtc_sync_left = 7'(SYNC_BUSY_TICKS_DEF);
          end
          ADDR_CMPL: begin
            cmp_q         = {temp_byte, item.write_data};
            rtc_status    = rtc_status | BUSY_CMP;
            rtc_sync_left = 7'(SYNC_BUSY_TICKS_DEF);
          end
          ADDR_PITCTRLA: begin
            pit_ctl       = item.write_data;
            pit_status    = pit_status | BUSY_CTRLA;
            pit_sync_left = 7'(SYNC_BUSY_TICKS_DEF);
          end
          ADDR_PITINTCTRL:  pit_int_en = item.write_data;
          ADDR_PITINTFLAGS: pit_int_fl = pit_int_fl & ~item.write_data;
          default: ;
        endcase
      end
      CMD_TICK: begin
        // Busy counts run down on every tick, enabled or not, and clear the
        // whole status register when they expire.
        if (rtc_sync_left != '0) begin
          if (rtc_sync_left == 7'd1) begin
            rtc_sync_left = '0;
            rtc_status    = '0;
          end else begin
            rtc_sync_left = rtc_sync_left - 7'd1;
          end
        end
        if (pit_sync_left != '0) begin
          if (pit_sync_left == 7'd1) begin
            pit_sync_left = '0;
            pit_status    = '0;
          end else begin
            pit_sync_left = pit_sync_left - 7'd1;
          end
        end
        if (ctl_a[0]) begin
          p       = ctl_a[6:3];
          div     = 11'd1 << ((p > 4'd10) ? 4'd10 : p);
          presc_q = presc_q + 11'd1;
          // A count already past a newly chosen divider fires at once.
          if (presc_q >= div) begin
            presc_q = '0;
            if (cnt_q == per_q) begin
              cnt_q              = '0;
              rtc_int_fl[0]      = 1'b1;
              res.overflow_event = 1'b1;
            end else begin
              cnt_q = cnt_q + 16'd1;
            end
            if (cnt_q == cmp_q) begin
              rtc_int_fl[1]     = 1'b1;
              res.compare_event = 1'b1;
            end
          end
        end
        if (pit_ctl[0]) begin
          p       = pit_ctl[6:3];
          pit_len = (p == 4'd0) ? 17'd4 : (17'd1 << ({1'b0, p} + 5'd1));
          pit_q   = pit_q + 17'd1;
          if (pit_q >= pit_len) begin
            pit_q         = '0;
            pit_int_fl[0] = 1'b1;
          end
        end
      end
      default: begin
        // Acknowledge: the RTC vector wins over the PIT vector.
        if ((rtc_int_fl & rtc_int_en & 8'h03) != '0) begin
          rtc_int_fl     = rtc_int_fl & ~8'h03;
          res.ack_vector = ACK_RTC;
        end else if (pit_int_fl[0] && pit_int_en[0]) begin
          pit_int_fl[0]  = 1'b0;
          res.ack_vector = ACK_PIT;
        end else begin
          res.ack_vector = ACK_NONE;
        end
      end
    endcase
    res.rtc_irq_pending = ((rtc_int_fl & rtc_int_en & 8'h03) != '0);
    res.pit_irq_pending = pit_int_fl[0] && pit_int_en[0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Sending side. An item is offered from a falling edge and held until the
  // rising edge at which the core takes it; only then is its reply worked
  // out and queued.
  // --------------------------------------------------------------------------
  rpit_out_t   replies_due[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent     = 0;
  int unsigned error_count    = 0;
  bit          hold_request   = 1'b0;
  int unsigned hold_left      = 0;

  logic [4:0] known_regs [12] = '{ADDR_CTRLA, ADDR_STATUS, ADDR_INTCTRL, ADDR_INTFLAGS,
                                   ADDR_TEMP, ADDR_CNTH, ADDR_PERH, ADDR_CMPH,
                                   ADDR_PITCTRLA, ADDR_PITSTATUS, ADDR_PITINTCTRL,
                                   ADDR_PITINTFLAGS};

  // When typed is set, the reply is taken as the given read byte with every
  // other field zero; the model still runs so that its state keeps step.
  task automatic send_item(input rpit_in_t item, input bit typed, input logic [7:0] typed_rd);
    rpit_out_t reply;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    reply = rtc_pit_reply(item);
    if (typed) begin
      reply           = '0;
      reply.read_data = typed_rd;
    end
    replies_due.push_back(reply);
    items_sent++;
    @(negedge clk_i);
  endtask

  // One random operation, which may take two items: 16-bit registers are
  // written high byte first and read low byte first, as software would.
  // Values are kept small so that overflow, compare and PIT flags come often.
  task automatic send_random_op();
    rpit_in_t    item;
    int unsigned pick;
    logic [3:0]  sel_exp;
    logic [4:0]  lo_addr;
    logic        en;
    pick            = $urandom_range(99, 0);
    item.command    = CMD_WRITE;
    item.address    = 5'($urandom);
    item.write_data = 8'($urandom);
    en              = ($urandom_range(9, 0) != 0);
    sel_exp         = ($urandom_range(9, 0) == 0) ? 4'($urandom) : 4'($urandom_range(2, 0));
    case ($urandom_range(2, 0))
      0:       lo_addr = ADDR_CNTL;
      1:       lo_addr = ADDR_PERL;
      default: lo_addr = ADDR_CMPL;
    endcase
    if (pick < 45) begin
      item.command = CMD_TICK;
      send_item(item, 1'b0, 8'h00);
    end else if (pick < 57) begin
      item.command = CMD_READ;
      if ($urandom_range(1, 0) == 0) begin
        item.address = known_regs[$urandom_range(11, 0)];
        send_item(item, 1'b0, 8'h00);
      end else begin
        item.address = lo_addr;
        send_item(item, 1'b0, 8'h00);
        item.address = lo_addr + 5'd1;
        send_item(item, 1'b0, 8'h00);
      end
    end else if (pick < 72) begin
      // High byte through its own offset or through temp, then the low byte.
      item.address    = ($urandom_range(3, 0) == 0) ? ADDR_TEMP : lo_addr + 5'd1;
      item.write_data = ($urandom_range(4, 0) == 0) ? 8'($urandom) : 8'h00;
      send_item(item, 1'b0, 8'h00);
      item.address    = lo_addr;
      item.write_data = ($urandom_range(9, 0) == 0) ? 8'($urandom) : 8'($urandom_range(24, 2));
      send_item(item, 1'b0, 8'h00);
    end else if (pick < 80) begin
      item.address    = ADDR_CTRLA;
      item.write_data = {1'($urandom), sel_exp, 2'($urandom), en};
      send_item(item, 1'b0, 8'h00);
    end else if (pick < 85) begin
      item.address    = ADDR_PITCTRLA;
      item.write_data = {1'($urandom), sel_exp, 2'($urandom), en};
      send_item(item, 1'b0, 8'h00);
    end else if (pick < 89) begin
      item.address = $urandom_range(1, 0) ? ADDR_INTCTRL : ADDR_PITINTCTRL;
      send_item(item, 1'b0, 8'h00);
    end else if (pick < 93) begin
      item.address = $urandom_range(1, 0) ? ADDR_INTFLAGS : ADDR_PITINTFLAGS;
      send_item(item, 1'b0, 8'h00);
    end else if (pick < 97) begin
      item.command = CMD_ACK;
      send_item(item, 1'b0, 8'h00);
    end else begin
      // Noise: any command, any offset, any byte.
      item = $bits(rpit_in_t)'($urandom);
      send_item(item, 1'b0, 8'h00);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiving side. The stall is changed at falling edges; a requested
  // hold-off keeps it high so that the core fills up and stalls its own input.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_OFF_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    rpit_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (replies_due.size() == 0) begin
        $error("reply %h arrived with no item outstanding", out_data_o);
        error_count++;
      end else begin
        want = replies_due.pop_front();
        check_field("read_data", want.read_data, out_data_o.read_data);
        check_field("overflow_event", want.overflow_event, out_data_o.overflow_event);
        check_field("compare_event", want.compare_event, out_data_o.compare_event);
        check_field("rtc_irq_pending", want.rtc_irq_pending, out_data_o.rtc_irq_pending);
        check_field("pit_irq_pending", want.pit_irq_pending, out_data_o.pit_irq_pending);
        check_field("ack_vector", want.ack_vector, out_data_o.ack_vector);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed table and main sequence.
  // --------------------------------------------------------------------------
  typedef struct {
    rpit_in_t   item;
    bit         typed;
    logic [7:0] read_byte;
  } directed_row_t;

  directed_row_t directed_rows[$];

  task automatic add_row(input rpit_cmd_e cmd, input logic [4:0] addr, input logic [7:0] data,
                         input bit typed, input logic [7:0] read_byte);
    directed_row_t row;
    row.item.command    = cmd;
    row.item.address    = addr;
    row.item.write_data = data;
    row.typed           = typed;
    row.read_byte       = read_byte;
    directed_rows.push_back(row);
  endtask

  initial begin
    int unsigned phase_target;
    int unsigned drain_cycles;

    // Straight after reset: the period reads back at its maximum through
    // temp, everything else reads zero, unknown offsets read zero, and an
    // acknowledge or a tick with nothing enabled does nothing.
    add_row(CMD_READ,  ADDR_PERL,        8'h00, 1'b1, 8'hFF);
    add_row(CMD_READ,  ADDR_PERH,        8'h00, 1'b1, 8'hFF);
    add_row(CMD_READ,  ADDR_CNTL,        8'hFF, 1'b1, 8'h00);
    add_row(CMD_READ,  5'd31,            8'hFF, 1'b1, 8'h00);
    add_row(CMD_ACK,   5'd31,            8'hFF, 1'b1, 8'h00);
    add_row(CMD_TICK,  5'd31,            8'hFF, 1'b1, 8'h00);
    // A short period and compare, both interrupts enabled, the fastest rates.
    add_row(CMD_WRITE, ADDR_TEMP,        8'h00, 1'b0, 8'h00);
    add_row(CMD_WRITE, ADDR_PERL,        8'h03, 1'b0, 8'h00);
    add_row(CMD_WRITE, ADDR_CMPH,        8'h00, 1'b0, 8'h00);
    add_row(CMD_WRITE, ADDR_CMPL,        8'h02, 1'b0, 8'h00);
    add_row(CMD_WRITE, ADDR_INTCTRL,     8'h03, 1'b0, 8'h00);
    add_row(CMD_WRITE, ADDR_PITINTCTRL,  8'h01, 1'b0, 8'h00);
    add_row(CMD_WRITE, ADDR_PITCTRLA,    8'h01, 1'b0, 8'h00);
    add_row(CMD_WRITE, ADDR_CTRLA,       8'h01, 1'b0, 8'h00);
    add_row(CMD_READ,  ADDR_STATUS,      8'h00, 1'b0, 8'h00);
    // Compare match on the second tick, overflow and PIT period on the fourth.
    repeat (4) add_row(CMD_TICK, ADDR_CTRLA, 8'h00, 1'b0, 8'h00);
    // Two acknowledges: the RTC vector first, then the PIT vector.
    add_row(CMD_ACK,   ADDR_CTRLA,       8'h00, 1'b0, 8'h00);
    add_row(CMD_ACK,   ADDR_CTRLA,       8'h00, 1'b0, 8'h00);
    add_row(CMD_WRITE, ADDR_INTFLAGS,    8'hFF, 1'b0, 8'h00);
    // Slowest settings on both timers; writes to read-only and unknown
    // offsets are ignored.
    add_row(CMD_WRITE, ADDR_CTRLA,       8'hFF, 1'b0, 8'h00);
    add_row(CMD_WRITE, ADDR_PITCTRLA,    8'hFF, 1'b0, 8'h00);
    add_row(CMD_WRITE, ADDR_STATUS,      8'hFF, 1'b0, 8'h00);
    add_row(CMD_WRITE, 5'd31,            8'hFF, 1'b0, 8'h00);
    add_row(CMD_READ,  ADDR_PITSTATUS,   8'h00, 1'b0, 8'h00);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].read_byte);
    end

    // Random phases: free running with one long receiver hold-off, then a
    // mostly idle sender, then a mostly stalling receiver, then both at 24%.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_request   = 1'b1;
        end
        1: begin
          send_idle_pct  = 70;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 70;
        end
        default: begin
          send_idle_pct  = 24;
          recv_stall_pct = 24;
        end
      endcase
      phase_target = items_sent + PHASE_ITEMS;
      while (items_sent < phase_target) send_random_op();
    end

    in_valid_i <= 1'b0;
    drain_cycles = 0;
    while (replies_due.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (replies_due.size() != 0) begin
      $error("%0d replies never arrived", replies_due.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/rpit_pkg.sv
src/rpit_rtc.sv
src/rpit_pit.sv
src/rtc_with_periodic_interrupt_timer_core.sv
src/rpit_checker.sv
sim/rtc_with_periodic_interrupt_timer_core_test.sv
